@@ hw/rtl/irkl_pkg.sv @@
// ----------------------------------------------------------------------------
// irkl_pkg
// Shared types, register indexes, key codes and helpers for the IR keypad
// color lock.
// ----------------------------------------------------------------------------
package irkl_pkg;

  // Default PIN length
  localparam int PIN_DIGITS_DEF = 4;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_MARK_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_MARK_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_SPACE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_SPACE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ONE_THRESH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNLOCK_CODE   = 3'd5;

  // Register reset values
  localparam logic [14:0] HDR_MARK_MIN_RST  = 15'd8000;
  localparam logic [14:0] HDR_MARK_MAX_RST  = 15'd10000;
  localparam logic [14:0] HDR_SPACE_MIN_RST = 15'd4000;
  localparam logic [14:0] HDR_SPACE_MAX_RST = 15'd5000;
  localparam logic [14:0] ONE_THRESH_RST    = 15'd1000;
  localparam logic [15:0] UNLOCK_CODE_RST   = 16'h1234;

  // Frame geometry
  localparam logic [5:0] SYM_IDX_MAX    = 6'd63;
  localparam logic [5:0] SYM_LAST_DATA  = 6'd32;
  localparam logic [5:0] SYM_MIN_FRAME  = 6'd33;
  localparam logic [7:0] CMD_CHECK      = 8'hFF;

  // Remote key codes
  localparam logic [7:0] KEY_STAR = 8'h16;
  localparam logic [7:0] KEY_HASH = 8'h0D;
  localparam logic [7:0] KEY_OK   = 8'h1C;

  localparam logic [7:0] KEY_D1 = 8'h45;
  localparam logic [7:0] KEY_D2 = 8'h46;
  localparam logic [7:0] KEY_D3 = 8'h47;
  localparam logic [7:0] KEY_D4 = 8'h44;
  localparam logic [7:0] KEY_D5 = 8'h40;
  localparam logic [7:0] KEY_D6 = 8'h43;
  localparam logic [7:0] KEY_D7 = 8'h07;
  localparam logic [7:0] KEY_D8 = 8'h15;
  localparam logic [7:0] KEY_D9 = 8'h09;
  localparam logic [7:0] KEY_D0 = 8'h19;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // Color entry stage
  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_RED   = 2'd1,
    STAGE_GREEN = 2'd2,
    STAGE_BLUE  = 2'd3
  } stage_t;

  typedef enum logic [1:0] {
    LOGIN_NONE   = 2'd0,
    LOGIN_ACCEPT = 2'd1,
    LOGIN_REJECT = 2'd2
  } login_t;

  typedef enum logic [1:0] {
    ARM_NONE    = 2'd0,
    ARM_LOGOUT  = 2'd1,
    ARM_REENTER = 2'd2
  } arm_t;

  // One IR symbol
  typedef struct packed {
    logic [14:0] mark_ticks;
    logic [14:0] space_ticks;
    logic        frame_end;
  } in_item_t;

  // One frame result
  typedef struct packed {
    logic       frame_ok;
    logic [7:0] key_code;
    logic       unlocked;
    logic [1:0] entry_stage;
    logic [7:0] entry_value;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       color_written;
    logic [1:0] login_result;
    logic [1:0] arm_status;
  } out_item_t;

  // Decoder timing registers
  typedef struct packed {
    logic [14:0] hdr_mark_min;
    logic [14:0] hdr_mark_max;
    logic [14:0] hdr_space_min;
    logic [14:0] hdr_space_max;
    logic [14:0] one_thresh;
  } timing_cfg_t;

  // Frame decoder to keypad: one event per closed frame
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] key;
  } frame_ev_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } key_digit_t;

  // Map a remote key to a decimal digit
  function automatic key_digit_t key_digit(input logic [7:0] key);
    key_digit_t kd;
    kd.hit = 1'b1;
    case (key)
      KEY_D1:  kd.value = 4'd1;
      KEY_D2:  kd.value = 4'd2;
      KEY_D3:  kd.value = 4'd3;
      KEY_D4:  kd.value = 4'd4;
      KEY_D5:  kd.value = 4'd5;
      KEY_D6:  kd.value = 4'd6;
      KEY_D7:  kd.value = 4'd7;
      KEY_D8:  kd.value = 4'd8;
      KEY_D9:  kd.value = 4'd9;
      KEY_D0:  kd.value = 4'd0;
      default: begin
        kd.hit   = 1'b0;
        kd.value = 4'd0;
      end
    endcase
    return kd;
  endfunction

endpackage

@@ hw/rtl/irkl_frame.sv @@
// ----------------------------------------------------------------------------
// irkl_frame
// NEC frame decoder: header check, 32-bit LSB-first shift, frame validation.
// ----------------------------------------------------------------------------
module irkl_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance_i,
  input  irkl_pkg::in_item_t   item_i,
  input  irkl_pkg::timing_cfg_t cfg_i,
  output irkl_pkg::frame_ev_t  ev_o
);
  import irkl_pkg::*;

  logic [5:0]  idx_r, idx_nxt, idx_inc, idx_m1;
  logic        hdr_r, hdr_nxt, hdr_upd;
  logic [31:0] bits_r, bits_nxt, bits_upd;
  logic [7:0]  cmd, inv;
  logic        ok;

  // Per-symbol update
  always_comb begin
    hdr_upd  = hdr_r;
    bits_upd = bits_r;
    idx_m1   = idx_r - 6'd1;
    if (idx_r == 6'd0) begin
      hdr_upd = (item_i.mark_ticks >= cfg_i.hdr_mark_min) &&
                (item_i.mark_ticks <= cfg_i.hdr_mark_max) &&
                (item_i.space_ticks >= cfg_i.hdr_space_min) &&
                (item_i.space_ticks <= cfg_i.hdr_space_max);
    end else if (idx_r <= SYM_LAST_DATA) begin
      if (item_i.space_ticks > cfg_i.one_thresh) begin
        bits_upd[idx_m1[4:0]] = 1'b1;
      end
    end
    idx_inc = (idx_r != SYM_IDX_MAX) ? idx_r + 6'd1 : idx_r;
  end

  // Frame check on the closing symbol
  assign cmd = bits_upd[23:16];
  assign inv = bits_upd[31:24];
  assign ok  = (idx_inc >= SYM_MIN_FRAME) && hdr_upd && (bits_upd != 32'd0) &&
               ((cmd ^ inv) == CMD_CHECK);

  // Closing symbol clears the frame state
  always_comb begin
    if (item_i.frame_end) begin
      idx_nxt  = 6'd0;
      hdr_nxt  = 1'b0;
      bits_nxt = 32'd0;
    end else begin
      idx_nxt  = idx_inc;
      hdr_nxt  = hdr_upd;
      bits_nxt = bits_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 6'd0;
      hdr_r  <= 1'b0;
      bits_r <= 32'd0;
    end else if (advance_i) begin
      idx_r  <= idx_nxt;
      hdr_r  <= hdr_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign ev_o.valid = advance_i && item_i.frame_end;
  assign ev_o.ok    = ok;
  assign ev_o.key   = ok ? cmd : 8'd0;

endmodule

@@ hw/rtl/irkl_keypad.sv @@
// ----------------------------------------------------------------------------
// irkl_keypad
// PIN lock and RGB entry sequencer driven by decoded remote keys.
// ----------------------------------------------------------------------------
module irkl_keypad #(
  parameter int PIN_DIGITS = irkl_pkg::PIN_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  irkl_pkg::frame_ev_t ev_i,
  input  logic [15:0]         unlock_code_i,
  output irkl_pkg::out_item_t res_o
);
  import irkl_pkg::*;

  localparam int CNT_W = $clog2(PIN_DIGITS + 1);

  logic [3:0]       digits_r [PIN_DIGITS];
  logic [3:0]       digits_nxt [PIN_DIGITS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             boss_r, boss_nxt;
  logic             logout_r, logout_nxt;
  logic             reenter_r, reenter_nxt;
  stage_t           stage_r, stage_nxt;
  logic [7:0]       typed_r, typed_nxt;
  logic [7:0]       color_r [3];
  logic [7:0]       color_nxt [3];
  logic             pin_ok;
  logic [11:0]      typed_acc;
  key_digit_t       kd;
  login_t           login;
  logic             written;
  arm_t             arm;

  // PIN compare, first digit against top nibble
  always_comb begin
    pin_ok = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (digits_r[i] != unlock_code_i[15 - 4*i -: 4]) pin_ok = 1'b0;
    end
  end

  assign kd        = key_digit(ev_i.key);
  assign typed_acc = {4'd0, typed_r} * 12'd10 + {8'd0, kd.value};

  // Key handling
  always_comb begin
    digits_nxt  = digits_r;
    count_nxt   = count_r;
    boss_nxt    = boss_r;
    logout_nxt  = logout_r;
    reenter_nxt = reenter_r;
    stage_nxt   = stage_r;
    typed_nxt   = typed_r;
    color_nxt   = color_r;
    login       = LOGIN_NONE;
    written     = 1'b0;
    if (ev_i.valid && ev_i.ok) begin
      if (ev_i.key == KEY_STAR) begin
        // arm logout
        if (boss_r) begin
          logout_nxt  = 1'b1;
          reenter_nxt = 1'b0;
        end
      end else if (ev_i.key == KEY_HASH) begin
        if (boss_r && logout_r) begin
          boss_nxt    = 1'b0;
          logout_nxt  = 1'b0;
          reenter_nxt = 1'b0;
          stage_nxt   = STAGE_IDLE;
          typed_nxt   = 8'd0;
          count_nxt   = '0;
        end else if (boss_r && reenter_r) begin
          reenter_nxt = 1'b0;
          stage_nxt   = STAGE_RED;
          typed_nxt   = 8'd0;
        end else if (boss_r) begin
          reenter_nxt = 1'b1;
        end
      end else if (kd.hit) begin
        logout_nxt  = 1'b0;
        reenter_nxt = 1'b0;
        if (stage_r == STAGE_IDLE) begin
          // PIN digit; extra digits are dropped
          for (int i = 0; i < PIN_DIGITS; i++) begin
            if (count_r == CNT_W'(i)) digits_nxt[i] = kd.value;
          end
          if (count_r < CNT_W'(PIN_DIGITS)) count_nxt = count_r + CNT_W'(1);
        end else begin
          typed_nxt = (typed_acc > {4'd0, LEVEL_MAX}) ? LEVEL_MAX : typed_acc[7:0];
        end
      end else if (ev_i.key == KEY_OK) begin
        if (stage_r == STAGE_IDLE) begin
          if (!boss_r) begin
            if (pin_ok) begin
              boss_nxt  = 1'b1;
              stage_nxt = STAGE_RED;
              typed_nxt = 8'd0;
              login     = LOGIN_ACCEPT;
            end else begin
              login = LOGIN_REJECT;
            end
            count_nxt = '0;
          end
        end else begin
          typed_nxt = 8'd0;
          unique case (stage_r)
            STAGE_RED: begin
              color_nxt[0] = typed_r;
              stage_nxt    = STAGE_GREEN;
            end
            STAGE_GREEN: begin
              color_nxt[1] = typed_r;
              stage_nxt    = STAGE_BLUE;
            end
            STAGE_BLUE: begin
              color_nxt[2] = typed_r;
              stage_nxt    = STAGE_IDLE;
              written      = 1'b1;
            end
            default: stage_nxt = stage_r;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIN_DIGITS; i++) digits_r[i] <= 4'hF;
      count_r   <= '0;
      boss_r    <= 1'b0;
      logout_r  <= 1'b0;
      reenter_r <= 1'b0;
      stage_r   <= STAGE_IDLE;
      typed_r   <= 8'd0;
      for (int i = 0; i < 3; i++) color_r[i] <= 8'd0;
    end else if (ev_i.valid) begin
      digits_r  <= digits_nxt;
      count_r   <= count_nxt;
      boss_r    <= boss_nxt;
      logout_r  <= logout_nxt;
      reenter_r <= reenter_nxt;
      stage_r   <= stage_nxt;
      typed_r   <= typed_nxt;
      color_r   <= color_nxt;
    end
  end

  // Result reflects state after the key
  assign arm = logout_nxt ? ARM_LOGOUT : (reenter_nxt ? ARM_REENTER : ARM_NONE);

  assign res_o.frame_ok      = ev_i.ok;
  assign res_o.key_code      = ev_i.key;
  assign res_o.unlocked      = boss_nxt;
  assign res_o.entry_stage   = stage_nxt;
  assign res_o.entry_value   = typed_nxt;
  assign res_o.red_level     = color_nxt[0];
  assign res_o.green_level   = color_nxt[1];
  assign res_o.blue_level    = color_nxt[2];
  assign res_o.color_written = written;
  assign res_o.login_result  = login;
  assign res_o.arm_status    = arm;

endmodule

@@ hw/rtl/ir_keypad_color_lock.sv @@
// ----------------------------------------------------------------------------
// ir_keypad_color_lock
// NEC IR remote decoder driving a PIN lock and RGB color entry.
// ----------------------------------------------------------------------------
// One IR symbol is taken per clock cycle while in_stall is low. A symbol goes
// into the input register, is decoded and applied to the lock, and a frame
// that closes there puts its result in the output register. Symbols that do
// not close a frame never wait in the input register; a closing symbol waits
// there only while the previous result is held in the output register, and
// for as long as it waits in_stall is high. Timing registers and the PIN are
// written through the cfg port; the user must write them only while no frame
// is in flight, as the block itself does not enforce it.
module ir_keypad_color_lock #(
  parameter int PIN_DIGITS = irkl_pkg::PIN_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  irkl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output irkl_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [irkl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irkl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import irkl_pkg::*;

  timing_cfg_t timing_r, timing_nxt;
  logic [15:0] unlock_r, unlock_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        s1_block, s1_fire, in_accept;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  frame_ev_t   ev;
  out_item_t   res;

  // Configuration register writes
  always_comb begin
    timing_nxt = timing_r;
    unlock_nxt = unlock_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_HDR_MARK_MIN:  timing_nxt.hdr_mark_min  = cfg_wdata[14:0];
        CFG_IDX_HDR_MARK_MAX:  timing_nxt.hdr_mark_max  = cfg_wdata[14:0];
        CFG_IDX_HDR_SPACE_MIN: timing_nxt.hdr_space_min = cfg_wdata[14:0];
        CFG_IDX_HDR_SPACE_MAX: timing_nxt.hdr_space_max = cfg_wdata[14:0];
        CFG_IDX_ONE_THRESH:    timing_nxt.one_thresh    = cfg_wdata[14:0];
        CFG_IDX_UNLOCK_CODE:   unlock_nxt               = cfg_wdata;
        default:               unlock_nxt               = unlock_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.hdr_mark_min  <= HDR_MARK_MIN_RST;
      timing_r.hdr_mark_max  <= HDR_MARK_MAX_RST;
      timing_r.hdr_space_min <= HDR_SPACE_MIN_RST;
      timing_r.hdr_space_max <= HDR_SPACE_MAX_RST;
      timing_r.one_thresh    <= ONE_THRESH_RST;
      unlock_r               <= UNLOCK_CODE_RST;
    end else begin
      timing_r <= timing_nxt;
      unlock_r <= unlock_nxt;
    end
  end

  // Input register: a closing item waits only while the result is held
  assign s1_block  = s1_item_r.frame_end && out_valid_r && out_stall;
  assign s1_fire   = s1_valid_r && !s1_block;
  assign in_stall  = s1_valid_r && s1_block;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_item_r <= in_data;
  end

  irkl_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance_i (s1_fire),
    .item_i    (s1_item_r),
    .cfg_i     (timing_r),
    .ev_o      (ev)
  );

  irkl_keypad #(
    .PIN_DIGITS (PIN_DIGITS)
  ) u_keypad (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_i          (ev),
    .unlock_code_i (unlock_r),
    .res_o         (res)
  );

  // Result register
  assign out_valid_nxt = ev.valid ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_close_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid |=> out_valid_r)
    else $error("closed frame did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_item_r.frame_end && out_valid_r))
    else $error("input stalled without a held result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ev.valid)
    else $error("held result overwritten");

  a_written_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.color_written) |->
      (out_data_r.frame_ok && (out_data_r.entry_stage == STAGE_IDLE)))
    else $error("color committed outside idle stage");

  a_login_ok_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.login_result != LOGIN_NONE)) |->
      (out_data_r.frame_ok && (out_data_r.key_code == KEY_OK)))
    else $error("login result without an OK key");

endmodule

@@ tb/sv/tb_ir_keypad_color_lock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_keypad_color_lock
// Self-checking bench for the IR keypad color lock. IR frames are sent one
// symbol per item, with random gaps on the sender and random stalls on the
// result side. A frame-level model of the decoder, the PIN lock and the color
// entry predicts each result, and every accepted result is checked field by
// field. A directed table runs first, then random key sessions and noise
// under several timing and PIN settings.
// ----------------------------------------------------------------------------
module tb_ir_keypad_color_lock;
  import irkl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum logic [3:0] {
    FR_KEY, FR_LONE, FR_SHORT, FR_LONG, FR_BADHDR, FR_ZERO, FR_ONES, FR_BADCHK, FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  key;
    logic        typed;
    out_item_t   res;
  } dir_row_t;

  localparam out_item_t NO_FRAME = '0;
  localparam out_item_t PIN_REJECTED = '{frame_ok: 1'b1, key_code: KEY_OK, unlocked: 1'b0,
                                         entry_stage: STAGE_IDLE, entry_value: 8'd0,
                                         red_level: 8'd0, green_level: 8'd0,
                                         blue_level: 8'd0, color_written: 1'b0,
                                         login_result: LOGIN_REJECT, arm_status: ARM_NONE};

  localparam logic [7:0] DIGIT_KEYS [10] = '{KEY_D0, KEY_D1, KEY_D2, KEY_D3, KEY_D4,
                                             KEY_D5, KEY_D6, KEY_D7, KEY_D8, KEY_D9};

  // Directed frames: error cases, login, color entry, arming and logout
  localparam int NUM_ROWS = 29;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{FR_LONE,   8'h00,    1'b1, NO_FRAME},
    '{FR_SHORT,  KEY_OK,   1'b1, NO_FRAME},
    '{FR_BADHDR, KEY_OK,   1'b1, NO_FRAME},
    '{FR_ZERO,   8'h00,    1'b1, NO_FRAME},
    '{FR_ONES,   8'h00,    1'b1, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b1, PIN_REJECTED},
    '{FR_KEY,    KEY_STAR, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_HASH, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D1,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D2,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D3,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D4,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D5,   1'b0, NO_FRAME},
    '{FR_LONG,   KEY_OK,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D9,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D9,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D9,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D0,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D7,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_D3,   1'b0, NO_FRAME},
    '{FR_KEY,    KEY_HASH, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_HASH, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_STAR, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_HASH, 1'b0, NO_FRAME},
    '{FR_KEY,    KEY_OK,   1'b0, NO_FRAME}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the register file
  logic [14:0] hdr_mark_min, hdr_mark_max, hdr_space_min, hdr_space_max, one_thresh;
  logic [15:0] pin_code;

  // Model state
  logic [5:0]  sym_idx;
  bit          hdr_ok;
  logic [31:0] shift;
  logic [3:0]  pin_digits [4];
  int          ndigits;
  bit          boss;
  bit          exit_pending;
  bit          reenter_armed;
  stage_t      stage;
  logic [7:0]  typed;
  logic [7:0]  levels [3];

  out_item_t expected_frames [$];
  int        mismatches;
  int        symbols_sent;
  bit        sender_bursty;
  logic      quiet;
  int        stall_left;

  ir_keypad_color_lock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int digit_of(logic [7:0] key);
    for (int i = 0; i < 10; i++) begin
      if (DIGIT_KEYS[i] == key) return i;
    end
    return -1;
  endfunction

  // Advance the lock model by one symbol; a closing symbol yields a result
  task automatic step_lock(input in_item_t s, output bit closes, output out_item_t r);
    logic [7:0] cmd;
    bit         good;
    bit         pin_hit;
    int         d;
    int         t;
    login_t     login;
    bit         written;
    closes  = 1'b0;
    r       = '0;
    good    = 1'b0;
    cmd     = 8'd0;
    login   = LOGIN_NONE;
    written = 1'b0;
    if (sym_idx == 6'd0) begin
      hdr_ok = s.mark_ticks >= hdr_mark_min && s.mark_ticks <= hdr_mark_max &&
               s.space_ticks >= hdr_space_min && s.space_ticks <= hdr_space_max;
    end else if (sym_idx <= SYM_LAST_DATA && s.space_ticks > one_thresh) begin
      shift[sym_idx - 6'd1] = 1'b1;
    end
    if (sym_idx != SYM_IDX_MAX) sym_idx = sym_idx + 6'd1;
    if (!s.frame_end) return;
    closes = 1'b1;

    // Frame check: length, header, nonzero data, command against its inverse
    if (sym_idx >= SYM_MIN_FRAME && hdr_ok && shift != 32'd0 &&
        (shift[23:16] ^ shift[31:24]) == CMD_CHECK) begin
      good = 1'b1;
      cmd  = shift[23:16];
    end
    sym_idx = 6'd0;
    hdr_ok  = 1'b0;
    shift   = 32'd0;

    if (good) begin
      d = digit_of(cmd);
      if (cmd == KEY_STAR) begin
        if (boss) begin
          exit_pending  = 1'b1;
          reenter_armed = 1'b0;
        end
      end else if (cmd == KEY_HASH) begin
        if (boss && exit_pending) begin
          boss          = 1'b0;
          exit_pending  = 1'b0;
          reenter_armed = 1'b0;
          stage         = STAGE_IDLE;
          typed         = 8'd0;
          ndigits       = 0;
        end else if (boss && reenter_armed) begin
          reenter_armed = 1'b0;
          stage         = STAGE_RED;
          typed         = 8'd0;
        end else if (boss) begin
          reenter_armed = 1'b1;
        end
      end else if (d >= 0) begin
        exit_pending  = 1'b0;
        reenter_armed = 1'b0;
        if (stage == STAGE_IDLE) begin
          // digits past the PIN length are dropped
          if (ndigits < PIN_DIGITS_DEF) begin
            pin_digits[ndigits] = 4'(d);
            ndigits++;
          end
        end else begin
          t     = int'(typed) * 10 + d;
          typed = (t > 255) ? LEVEL_MAX : 8'(t);
        end
      end else if (cmd == KEY_OK) begin
        if (stage == STAGE_IDLE) begin
          if (!boss) begin
            pin_hit = 1'b1;
            for (int i = 0; i < PIN_DIGITS_DEF; i++) begin
              if (pin_digits[i] != pin_code[15 - 4 * i -: 4]) pin_hit = 1'b0;
            end
            if (pin_hit) begin
              boss  = 1'b1;
              stage = STAGE_RED;
              typed = 8'd0;
              login = LOGIN_ACCEPT;
            end else begin
              login = LOGIN_REJECT;
            end
            ndigits = 0;
          end
        end else begin
          levels[int'(stage) - 1] = typed;
          typed = 8'd0;
          if (stage == STAGE_BLUE) begin
            stage   = STAGE_IDLE;
            written = 1'b1;
          end else begin
            stage = stage_t'(stage + 2'd1);
          end
        end
      end
    end

    r.frame_ok      = good;
    r.key_code      = cmd;
    r.unlocked      = boss;
    r.entry_stage   = stage;
    r.entry_value   = typed;
    r.red_level     = levels[0];
    r.green_level   = levels[1];
    r.blue_level    = levels[2];
    r.color_written = written;
    r.login_result  = login;
    r.arm_status    = exit_pending ? ARM_LOGOUT : (reenter_armed ? ARM_REENTER : ARM_NONE);
  endtask

  // Send one symbol, predict on acceptance
  task automatic send_symbol(input in_item_t s, input bit use_typed, input out_item_t typed_res);
    bit        closes;
    out_item_t res;
    if (sender_bursty && $urandom_range(11, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    symbols_sent++;
    step_lock(s, closes, res);
    if (closes) expected_frames.push_back(use_typed ? typed_res : res);
  endtask

  // Build and send one IR frame of the given kind
  task automatic send_frame(input frame_kind_t kind, input logic [7:0] key, input bit extreme,
                            input bit use_typed, input out_item_t typed_res);
    logic [31:0] bits;
    int          n;
    int          j;
    in_item_t    s;
    bits = {~key, key, 16'($urandom)};
    n    = 33;
    case (kind)
      FR_ZERO:   bits = 32'd0;
      FR_ONES:   bits = '1;
      FR_BADCHK: begin
        j = 24 + $urandom_range(7, 0);
        bits[j] = ~bits[j];
      end
      FR_LONE:   n = 1;
      FR_SHORT:  n = extreme ? 32 : $urandom_range(32, 2);
      FR_LONG:   n = extreme ? 73 : $urandom_range(75, 34);
      FR_NOISE:  n = $urandom_range(70, 1);
      default: ;
    endcase
    sender_bursty = !quiet && $urandom_range(1, 0) == 1;
    for (int k = 0; k < n; k++) begin
      s.mark_ticks  = 15'($urandom);
      s.space_ticks = 15'($urandom);
      if (kind != FR_NOISE) begin
        if (k == 0 && kind == FR_BADHDR) begin
          s.mark_ticks = (hdr_mark_min != 15'd0) ? hdr_mark_min - 15'd1 : hdr_mark_max + 15'd1;
        end else if (k == 0) begin
          if (extreme) begin
            s.mark_ticks  = $urandom_range(1, 0) ? hdr_mark_min : hdr_mark_max;
            s.space_ticks = $urandom_range(1, 0) ? hdr_space_min : hdr_space_max;
          end else begin
            s.mark_ticks  = 15'($urandom_range(hdr_mark_max, hdr_mark_min));
            s.space_ticks = 15'($urandom_range(hdr_space_max, hdr_space_min));
          end
        end else if (k <= 32) begin
          if (extreme) s.mark_ticks = k[0] ? 15'h7FFF : 15'h0000;
          if (bits[k - 1]) begin
            s.space_ticks = (extreme || one_thresh == 15'h7FFF) ? 15'h7FFF :
                            15'($urandom_range(32767, int'(one_thresh) + 1));
          end else begin
            s.space_ticks = extreme ? 15'h0000 : 15'($urandom_range(one_thresh, 0));
          end
        end
      end
      s.frame_end = (k == n - 1);
      send_symbol(s, use_typed, typed_res);
    end
  endtask

  // One remote key press, now and then carried by an over-long frame
  task automatic press(input logic [7:0] key);
    send_frame(($urandom_range(19, 0) == 0) ? FR_LONG : FR_KEY, key, 1'b0, 1'b0, NO_FRAME);
  endtask

  // Random key sessions: login, color entry, arming, stray keys and noise
  task automatic run_sessions(input int budget);
    int pick;
    int stop_at;
    bit pin_is_decimal;
    stop_at = symbols_sent + budget;
    while (symbols_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      pin_is_decimal = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (pin_code[15 - 4 * i -: 4] > 4'd9) pin_is_decimal = 1'b0;
      end
      if (pick < 30) begin
        if (pin_is_decimal && $urandom_range(3, 0) != 0) begin
          for (int i = 0; i < 4; i++) press(DIGIT_KEYS[pin_code[15 - 4 * i -: 4]]);
        end else begin
          repeat ($urandom_range(6, 0)) press(DIGIT_KEYS[$urandom_range(9, 0)]);
        end
        press(KEY_OK);
      end else if (pick < 60) begin
        repeat (3) begin
          repeat ($urandom_range(4, 0)) press(DIGIT_KEYS[$urandom_range(9, 0)]);
          press(KEY_OK);
        end
      end else if (pick < 70) begin
        press(KEY_STAR);
        press(($urandom_range(3, 0) != 0) ? KEY_HASH : DIGIT_KEYS[$urandom_range(9, 0)]);
      end else if (pick < 78) begin
        press(KEY_HASH);
        press(KEY_HASH);
      end else if (pick < 88) begin
        case ($urandom_range(3, 0))
          0:       press(KEY_STAR);
          1:       press(KEY_OK);
          2:       press(DIGIT_KEYS[$urandom_range(9, 0)]);
          default: press(8'($urandom));
        endcase
      end else begin
        send_frame(frame_kind_t'($urandom_range(8, 1)), 8'($urandom), 1'b0, 1'b0, NO_FRAME);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Drain all results, let the pipeline settle, then load a new register set
  task automatic apply_settings(input logic [14:0] mk_min, input logic [14:0] mk_max,
                                input logic [14:0] sp_min, input logic [14:0] sp_max,
                                input logic [14:0] thresh, input logic [15:0] pin);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_IDX_HDR_MARK_MIN, {1'b0, mk_min});
    write_reg(CFG_IDX_HDR_MARK_MAX, {1'b0, mk_max});
    write_reg(CFG_IDX_HDR_SPACE_MIN, {1'b0, sp_min});
    write_reg(CFG_IDX_HDR_SPACE_MAX, {1'b0, sp_max});
    write_reg(CFG_IDX_ONE_THRESH, {1'b0, thresh});
    write_reg(CFG_IDX_UNLOCK_CODE, pin);
    cfg_we        <= 1'b0;
    hdr_mark_min  = mk_min;
    hdr_mark_max  = mk_max;
    hdr_space_min = sp_min;
    hdr_space_max = sp_max;
    one_thresh    = thresh;
    pin_code      = pin;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stall bursts, none in the closing stretch
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(19, 0) == 0) begin
      stall_left = $urandom_range(17, 0);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result with no frame outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_ok", 8'(want.frame_ok), 8'(out_data.frame_ok));
        check_field("key_code", want.key_code, out_data.key_code);
        check_field("unlocked", 8'(want.unlocked), 8'(out_data.unlocked));
        check_field("entry_stage", 8'(want.entry_stage), 8'(out_data.entry_stage));
        check_field("entry_value", want.entry_value, out_data.entry_value);
        check_field("red_level", want.red_level, out_data.red_level);
        check_field("green_level", want.green_level, out_data.green_level);
        check_field("blue_level", want.blue_level, out_data.blue_level);
        check_field("color_written", 8'(want.color_written), 8'(out_data.color_written));
        check_field("login_result", 8'(want.login_result), 8'(out_data.login_result));
        check_field("arm_status", 8'(want.arm_status), 8'(out_data.arm_status));
      end
    end
  end

  // Watchdog: cycles without any handshake on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_ir_keypad_color_lock failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    quiet     <= 1'b0;
    mismatches    = 0;
    symbols_sent  = 0;
    sender_bursty = 1'b0;

    // model state and registers after reset
    hdr_mark_min  = HDR_MARK_MIN_RST;
    hdr_mark_max  = HDR_MARK_MAX_RST;
    hdr_space_min = HDR_SPACE_MIN_RST;
    hdr_space_max = HDR_SPACE_MAX_RST;
    one_thresh    = ONE_THRESH_RST;
    pin_code      = UNLOCK_CODE_RST;
    sym_idx       = 6'd0;
    hdr_ok        = 1'b0;
    shift         = 32'd0;
    for (int i = 0; i < 4; i++) pin_digits[i] = 4'hF;
    ndigits       = 0;
    boss          = 1'b0;
    exit_pending  = 1'b0;
    reenter_armed = 1'b0;
    stage         = STAGE_IDLE;
    typed         = 8'd0;
    for (int i = 0; i < 3; i++) levels[i] = 8'd0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_frame(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].key, 1'b1,
                 DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    end

    // widest windows, every nonzero space a one bit, all-zero PIN
    apply_settings(15'd0, 15'h7FFF, 15'd0, 15'h7FFF, 15'd0, 16'h0000);
    run_sessions(60);
    // single-value header window at the top of the range
    apply_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFE, 16'h9999);
    run_sessions(60);
    // reversed header bounds: nothing decodes
    apply_settings(15'd20000, 15'd100, 15'd30000, 15'd50, 15'd500, 16'hFFFF);
    run_sessions(30);
    repeat (2) begin
      apply_settings(15'($urandom_range(20000, 0)), 15'($urandom_range(32767, 20000)),
                     15'($urandom_range(15000, 0)), 15'($urandom_range(32767, 15000)),
                     15'($urandom_range(20000, 0)),
                     {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0)),
                      4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))});
      run_sessions(60);
    end
    // closing stretch at reset values, no idling on either side
    quiet <= 1'b1;
    apply_settings(HDR_MARK_MIN_RST, HDR_MARK_MAX_RST, HDR_SPACE_MIN_RST, HDR_SPACE_MAX_RST,
                   ONE_THRESH_RST, UNLOCK_CODE_RST);
    run_sessions(100);

    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ir_keypad_color_lock passed");
    end else begin
      $display("tb_ir_keypad_color_lock failed");
    end
    $finish;
  end

endmodule
